// ----- design/pps_pkg.sv -----
// Package for the pick-and-place cycle sequencer: state and event types,
// command bytes, register indexes, reset values and the state-code mapping.
// No dependencies.
`default_nettype none

package pps_pkg;

    // Field widths
    localparam int unsigned POS_W     = 16;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned CODE_W    = 5;
    localparam int unsigned EVENT_W   = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Command bytes
    localparam logic [BYTE_W-1:0] CMD_HOME  = 8'h68;  // 'h'
    localparam logic [BYTE_W-1:0] CMD_START = 8'h73;  // 's'

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_POSITION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_DELAY_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_HOLD_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLACE_DELAY_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLACE_HOLD_MS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRACT_WAIT_MS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIEVE_WAIT_MS = 3'd6;

    // Register reset values
    localparam logic signed [POS_W-1:0] RST_PICK_POSITION = -16'sd1000;
    localparam logic [MS_W-1:0] RST_PICK_DELAY_MS    = 16'd10;
    localparam logic [MS_W-1:0] RST_PICK_HOLD_MS     = 16'd300;
    localparam logic [MS_W-1:0] RST_PLACE_DELAY_MS   = 16'd100;
    localparam logic [MS_W-1:0] RST_PLACE_HOLD_MS    = 16'd100;
    localparam logic [MS_W-1:0] RST_RETRACT_WAIT_MS  = 16'd100;
    localparam logic [MS_W-1:0] RST_RETRIEVE_WAIT_MS = 16'd200;

    typedef enum logic [17:0] {
        ST_IDLE            = 18'h00001,
        ST_HOME_REQ        = 18'h00002,
        ST_HOMING_X        = 18'h00004,
        ST_HOMING_Y        = 18'h00008,
        ST_AWAIT           = 18'h00010,
        ST_MOVE_PICK       = 18'h00020,
        ST_PICKING         = 18'h00040,
        ST_RETR_PART       = 18'h00080,
        ST_MOVE_PLACE      = 18'h00100,
        ST_PLACING         = 18'h00200,
        ST_RETR_PLACE      = 18'h00400,
        ST_WAIT_RETR       = 18'h00800,
        ST_RETRIEVING      = 18'h01000,
        ST_RETR_RETR       = 18'h02000,
        ST_MOVE_ORIGIN     = 18'h04000,
        ST_PLACE_ORIGIN    = 18'h08000,
        ST_RETR_EMPTY      = 18'h10000,
        ST_RET_HOME        = 18'h20000
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE        = 3'd0,
        EV_HOME_START  = 3'd1,
        EV_X_HOMED     = 3'd2,
        EV_HOME_DONE   = 3'd3,
        EV_CYCLE_START = 3'd4,
        EV_NOT_HOMED   = 3'd5,
        EV_CYCLE_DONE  = 3'd6
    } t_event;

    // Externally visible state number, in declaration order
    function automatic logic [CODE_W-1:0] phase_code(input t_phase ph);
        logic [CODE_W-1:0] code;
        case (ph)
            ST_IDLE:         code = 5'd0;
            ST_HOME_REQ:     code = 5'd1;
            ST_HOMING_X:     code = 5'd2;
            ST_HOMING_Y:     code = 5'd3;
            ST_AWAIT:        code = 5'd4;
            ST_MOVE_PICK:    code = 5'd5;
            ST_PICKING:      code = 5'd6;
            ST_RETR_PART:    code = 5'd7;
            ST_MOVE_PLACE:   code = 5'd8;
            ST_PLACING:      code = 5'd9;
            ST_RETR_PLACE:   code = 5'd10;
            ST_WAIT_RETR:    code = 5'd11;
            ST_RETRIEVING:   code = 5'd12;
            ST_RETR_RETR:    code = 5'd13;
            ST_MOVE_ORIGIN:  code = 5'd14;
            ST_PLACE_ORIGIN: code = 5'd15;
            ST_RETR_EMPTY:   code = 5'd16;
            ST_RET_HOME:     code = 5'd17;
            default:         code = 5'd0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- design/pick_place_cycle_sequencer.sv -----
// A request passes through the input register, then the result register. One request
// per clock, back to back, while the result is not stalled; the result register lets a new
// request into the input register while the previous result waits to be taken.
// Reset (synchronous, active low): state IDLE, elapsed count zero, arm retracted,
// suction off, both stages empty, configuration registers at their defaults.
// Depends on pps_pkg.
`default_nettype none

module pick_place_cycle_sequencer (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [pps_pkg::MS_W-1:0]             i_cfg_data,

    // request channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_ms_tick,
    input  wire logic                                 i_rx_valid,
    input  wire logic [pps_pkg::BYTE_W-1:0]           i_rx_byte,
    input  wire logic                                 i_x_endstop_hit,
    input  wire logic                                 i_y_endstop_hit,
    input  wire logic                                 i_x_move_done,
    input  wire logic                                 i_y_move_done,
    input  wire logic                                 i_x_at_zero,
    input  wire logic                                 i_y_at_zero,

    // result channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [pps_pkg::CODE_W-1:0]                o_state_code,
    output logic                                      o_arm_extended,
    output logic                                      o_suction_on,
    output logic signed [pps_pkg::POS_W-1:0]          o_axis_target,
    output logic                                      o_move_request,
    output logic                                      o_home_x_run,
    output logic                                      o_home_y_run,
    output logic                                      o_zero_x,
    output logic                                      o_zero_y,
    output logic [pps_pkg::EVENT_W-1:0]               o_event_code
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [pps_pkg::POS_W-1:0] r_pick_position;
    logic [pps_pkg::MS_W-1:0]         r_pick_delay_ms;
    logic [pps_pkg::MS_W-1:0]         r_pick_hold_ms;
    logic [pps_pkg::MS_W-1:0]         r_place_delay_ms;
    logic [pps_pkg::MS_W-1:0]         r_place_hold_ms;
    logic [pps_pkg::MS_W-1:0]         r_retract_wait_ms;
    logic [pps_pkg::MS_W-1:0]         r_retrieve_wait_ms;

    // Writes beyond the register list fall into the default arm and are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_position    <= pps_pkg::RST_PICK_POSITION;
            r_pick_delay_ms    <= pps_pkg::RST_PICK_DELAY_MS;
            r_pick_hold_ms     <= pps_pkg::RST_PICK_HOLD_MS;
            r_place_delay_ms   <= pps_pkg::RST_PLACE_DELAY_MS;
            r_place_hold_ms    <= pps_pkg::RST_PLACE_HOLD_MS;
            r_retract_wait_ms  <= pps_pkg::RST_RETRACT_WAIT_MS;
            r_retrieve_wait_ms <= pps_pkg::RST_RETRIEVE_WAIT_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pps_pkg::CFG_PICK_POSITION:    r_pick_position    <= $signed(i_cfg_data);
                pps_pkg::CFG_PICK_DELAY_MS:    r_pick_delay_ms    <= i_cfg_data;
                pps_pkg::CFG_PICK_HOLD_MS:     r_pick_hold_ms     <= i_cfg_data;
                pps_pkg::CFG_PLACE_DELAY_MS:   r_place_delay_ms   <= i_cfg_data;
                pps_pkg::CFG_PLACE_HOLD_MS:    r_place_hold_ms    <= i_cfg_data;
                pps_pkg::CFG_RETRACT_WAIT_MS:  r_retract_wait_ms  <= i_cfg_data;
                pps_pkg::CFG_RETRIEVE_WAIT_MS: r_retrieve_wait_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the pipeline advances when the result register is free
    // or its content is being taken this cycle.
    // ------------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic w_out_free;
    logic w_adv;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                          r_in_tick;
    logic                          r_in_rx_valid;
    logic [pps_pkg::BYTE_W-1:0]    r_in_rx_byte;
    logic                          r_in_x_end;
    logic                          r_in_y_end;
    logic                          r_in_done;
    logic                          r_in_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Fold the per-axis move-done and at-zero flags here: the sequencer only needs those for both axes together.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_tick     <= i_ms_tick;
            r_in_rx_valid <= i_rx_valid;
            r_in_rx_byte  <= i_rx_byte;
            r_in_x_end    <= i_x_endstop_hit;
            r_in_y_end    <= i_y_endstop_hit;
            r_in_done     <= i_x_move_done && i_y_move_done;
            r_in_zero     <= i_x_at_zero && i_y_at_zero;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    pps_pkg::t_phase                   r_phase;
    logic [pps_pkg::ELAPSED_W-1:0]     r_elapsed;
    logic                              r_extend;
    logic                              r_suction;

    pps_pkg::t_phase                   n_phase;
    logic [pps_pkg::ELAPSED_W-1:0]     n_elapsed;
    logic                              n_extend;
    logic                              n_suction;

    logic [pps_pkg::ELAPSED_W-1:0]     w_elapsed;
    logic [pps_pkg::ELAPSED_W-1:0]     w_pick_delay;
    logic [pps_pkg::ELAPSED_W-1:0]     w_pick_end;
    logic [pps_pkg::ELAPSED_W-1:0]     w_place_delay;
    logic [pps_pkg::ELAPSED_W-1:0]     w_place_end;
    logic [pps_pkg::ELAPSED_W-1:0]     w_retract_wait;
    logic [pps_pkg::ELAPSED_W-1:0]     w_retrieve_wait;

    logic signed [pps_pkg::POS_W-1:0]  w_target;
    logic                              w_move_req;
    logic                              w_home_x;
    logic                              w_home_y;
    logic                              w_zero_x;
    logic                              w_zero_y;
    pps_pkg::t_event                   w_event;

    // Window bounds are one bit wider than the registers, so delay plus hold
    // never wraps.
    assign w_pick_delay    = {1'b0, r_pick_delay_ms};
    assign w_pick_end      = {1'b0, r_pick_delay_ms} + {1'b0, r_pick_hold_ms};
    assign w_place_delay   = {1'b0, r_place_delay_ms};
    assign w_place_end     = {1'b0, r_place_delay_ms} + {1'b0, r_place_hold_ms};
    assign w_retract_wait  = {1'b0, r_retract_wait_ms};
    assign w_retrieve_wait = {1'b0, r_retrieve_wait_ms};

    // Count the tick first, saturating; every decision below sees the new count.
    assign w_elapsed = (r_in_tick && (r_elapsed != pps_pkg::ELAPSED_MAX))
                     ? r_elapsed + pps_pkg::ELAPSED_W'(1) : r_elapsed;

    always_comb begin
        n_phase    = r_phase;
        n_extend   = r_extend;
        n_suction  = r_suction;
        w_target   = '0;
        w_move_req = 1'b0;
        w_home_x   = 1'b0;
        w_home_y   = 1'b0;
        w_zero_x   = 1'b0;
        w_zero_y   = 1'b0;
        w_event    = pps_pkg::EV_NONE;

        case (r_phase)
            pps_pkg::ST_IDLE, pps_pkg::ST_AWAIT: begin
                // Take commands only here; any other byte is dropped.
                if (r_in_rx_valid) begin
                    if (r_in_rx_byte == pps_pkg::CMD_HOME) begin
                        w_event = pps_pkg::EV_HOME_START;
                        n_phase = pps_pkg::ST_HOME_REQ;
                    end else if (r_in_rx_byte == pps_pkg::CMD_START) begin
                        if (r_in_zero) begin
                            w_event    = pps_pkg::EV_CYCLE_START;
                            n_phase    = pps_pkg::ST_MOVE_PICK;
                            w_target   = r_pick_position;
                            w_move_req = 1'b1;
                        end else begin
                            // Start refused until both axes sit at zero.
                            w_event = pps_pkg::EV_NOT_HOMED;
                        end
                    end
                end
            end
            pps_pkg::ST_HOME_REQ: begin
                n_phase = pps_pkg::ST_HOMING_X;
            end
            pps_pkg::ST_HOMING_X: begin
                if (r_in_x_end) begin
                    w_zero_x = 1'b1;
                    w_event  = pps_pkg::EV_X_HOMED;
                    n_phase  = pps_pkg::ST_HOMING_Y;
                end else begin
                    w_home_x = 1'b1;
                end
            end
            pps_pkg::ST_HOMING_Y: begin
                if (r_in_y_end) begin
                    w_zero_y = 1'b1;
                    w_event  = pps_pkg::EV_HOME_DONE;
                    n_phase  = pps_pkg::ST_AWAIT;
                end else begin
                    w_home_y = 1'b1;
                end
            end
            pps_pkg::ST_MOVE_PICK: begin
                w_target   = r_pick_position;
                w_move_req = 1'b1;
                if (r_in_done) begin
                    n_phase = pps_pkg::ST_PICKING;
                end
            end
            pps_pkg::ST_MOVE_ORIGIN: begin
                w_target   = r_pick_position;
                w_move_req = 1'b1;
                if (r_in_done) begin
                    n_phase = pps_pkg::ST_PLACE_ORIGIN;
                end
            end
            pps_pkg::ST_MOVE_PLACE: begin
                // Place position is the home position, target zero.
                w_move_req = 1'b1;
                if (r_in_done) begin
                    n_phase = pps_pkg::ST_PLACING;
                end
            end
            pps_pkg::ST_RET_HOME: begin
                w_move_req = 1'b1;
                if (r_in_done) begin
                    w_event = pps_pkg::EV_CYCLE_DONE;
                    n_phase = pps_pkg::ST_AWAIT;
                end
            end
            pps_pkg::ST_PICKING, pps_pkg::ST_RETRIEVING: begin
                // Wait, then extend with suction for the hold window, then move on.
                if (w_elapsed >= w_pick_delay) begin
                    if (w_elapsed < w_pick_end) begin
                        n_extend  = 1'b1;
                        n_suction = 1'b1;
                    end else if (r_phase == pps_pkg::ST_PICKING) begin
                        n_phase = pps_pkg::ST_RETR_PART;
                    end else begin
                        n_phase = pps_pkg::ST_RETR_RETR;
                    end
                end
            end
            pps_pkg::ST_PLACING, pps_pkg::ST_PLACE_ORIGIN: begin
                // Wait, then extend for the hold window, then release suction.
                if (w_elapsed >= w_place_delay) begin
                    if (w_elapsed < w_place_end) begin
                        n_extend = 1'b1;
                    end else begin
                        n_suction = 1'b0;
                        if (r_phase == pps_pkg::ST_PLACING) begin
                            n_phase = pps_pkg::ST_RETR_PLACE;
                        end else begin
                            n_phase = pps_pkg::ST_RETR_EMPTY;
                        end
                    end
                end
            end
            pps_pkg::ST_RETR_PART: begin
                if (w_elapsed >= w_retract_wait) begin
                    n_extend = 1'b0;
                    n_phase  = pps_pkg::ST_MOVE_PLACE;
                end
            end
            pps_pkg::ST_RETR_PLACE: begin
                if (w_elapsed >= w_retract_wait) begin
                    n_extend = 1'b0;
                    n_phase  = pps_pkg::ST_WAIT_RETR;
                end
            end
            pps_pkg::ST_RETR_RETR: begin
                if (w_elapsed >= w_retract_wait) begin
                    n_extend = 1'b0;
                    n_phase  = pps_pkg::ST_MOVE_ORIGIN;
                end
            end
            pps_pkg::ST_RETR_EMPTY: begin
                if (w_elapsed >= w_retract_wait) begin
                    n_extend = 1'b0;
                    n_phase  = pps_pkg::ST_RET_HOME;
                end
            end
            pps_pkg::ST_WAIT_RETR: begin
                if (w_elapsed >= w_retrieve_wait) begin
                    n_phase = pps_pkg::ST_RETRIEVING;
                end
            end
            default: begin
                n_phase = pps_pkg::ST_IDLE;
            end
        endcase

        // Restart the millisecond count on every change of state.
        n_elapsed = (n_phase != r_phase) ? '0 : w_elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pps_pkg::ST_IDLE;
            r_elapsed <= '0;
            r_extend  <= 1'b0;
            r_suction <= 1'b0;
        end else if (w_adv) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_extend  <= n_extend;
            r_suction <= n_suction;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [pps_pkg::CODE_W-1:0]        r_out_code;
    logic                              r_out_extend;
    logic                              r_out_suction;
    logic signed [pps_pkg::POS_W-1:0]  r_out_target;
    logic                              r_out_move_req;
    logic                              r_out_home_x;
    logic                              r_out_home_y;
    logic                              r_out_zero_x;
    logic                              r_out_zero_y;
    pps_pkg::t_event                   r_out_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_code     <= pps_pkg::phase_code(n_phase);
            r_out_extend   <= n_extend;
            r_out_suction  <= n_suction;
            r_out_target   <= w_target;
            r_out_move_req <= w_move_req;
            r_out_home_x   <= w_home_x;
            r_out_home_y   <= w_home_y;
            r_out_zero_x   <= w_zero_x;
            r_out_zero_y   <= w_zero_y;
            r_out_event    <= w_event;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_state_code   = r_out_code;
    assign o_arm_extended = r_out_extend;
    assign o_suction_on   = r_out_suction;
    assign o_axis_target  = r_out_target;
    assign o_move_request = r_out_move_req;
    assign o_home_x_run   = r_out_home_x;
    assign o_home_y_run   = r_out_home_y;
    assign o_zero_x       = r_out_zero_x;
    assign o_zero_y       = r_out_zero_y;
    assign o_event_code   = r_out_event;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The state and the elapsed count hold while no request is processed.
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_phase) && $stable(r_elapsed)))
        else $error("sequencer state moved without a request");

    // A change of state restarts the millisecond count.
    a_elapsed_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (n_phase != r_phase)) |=> (r_elapsed == '0))
        else $error("elapsed count not cleared on state change");

    // The arm is only ever extended in a pick, place or retract state.
    a_extend_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extend |-> (r_phase == pps_pkg::ST_PICKING || r_phase == pps_pkg::ST_RETRIEVING
                   || r_phase == pps_pkg::ST_PLACING || r_phase == pps_pkg::ST_PLACE_ORIGIN
                   || r_phase == pps_pkg::ST_RETR_PART || r_phase == pps_pkg::ST_RETR_PLACE
                   || r_phase == pps_pkg::ST_RETR_RETR || r_phase == pps_pkg::ST_RETR_EMPTY))
        else $error("arm extended outside a pick, place or retract state");

    // No target is presented without a move.
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_move_request) |-> (o_axis_target == '0))
        else $error("axis target set without move request");

    // Homing run and zeroing never coincide on an axis, nor does homing overlap a move.
    a_homing_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_home_x_run && o_zero_x) && !(o_home_y_run && o_zero_y)
                         && !(o_move_request && (o_home_x_run || o_home_y_run))))
        else $error("conflicting axis commands in one result");

endmodule

`default_nettype wire
